### hw/rtl/sha1sh_pkg.sv
// sha1sh_pkg: shared types, constants and round functions for the sha-1 hasher
// used by sha1sh_msg_sched, sha1sh_round_core and sha1_stream_hasher_unit
`default_nettype none

package sha1sh_pkg;

  // sizes
  localparam int unsigned BlockBytes = 64;
  localparam int unsigned MsgW       = BlockBytes * 8;
  localparam int unsigned PosW       = 6;
  localparam int unsigned LenW       = 64;
  localparam int unsigned NumRounds  = 80;
  localparam int unsigned RoundW     = 7;
  localparam int unsigned NumWords   = 5;
  localparam int unsigned WordIdxW   = 3;

  typedef logic [31:0] word_t;
  // element 0 is word 0 (a / h0)
  typedef logic [NumWords-1:0][31:0] chain_t;

  // initial chaining value, h0 in the low slot
  localparam chain_t HInit = {32'hC3D2E1F0, 32'h10325476, 32'h98BADCFE,
                              32'hEFCDAB89, 32'h67452301};

  // padding constants
  localparam logic [7:0]      PadMark = 8'h80;
  localparam logic [PosW-1:0] LenPos  = PosW'(448 / 8);
  localparam logic [PosW-1:0] PosLast = PosW'(BlockBytes - 1);

  // round groups of twenty
  typedef enum logic [1:0] {
    GrpChoose,
    GrpParityA,
    GrpMajority,
    GrpParityB
  } grp_e;

  // control from the sequencer to the message schedule
  typedef struct packed {
    logic       shift_byte;
    logic       shift_word;
    logic [7:0] byte_val;
  } sched_ctrl_t;

  // control from the sequencer to the round core
  typedef struct packed {
    logic load;
    logic step;
  } round_ctrl_t;

  function automatic grp_e round_grp(input logic [RoundW-1:0] idx);
    grp_e g;
    if (idx < RoundW'(20)) begin
      g = GrpChoose;
    end else if (idx < RoundW'(40)) begin
      g = GrpParityA;
    end else if (idx < RoundW'(60)) begin
      g = GrpMajority;
    end else begin
      g = GrpParityB;
    end
    return g;
  endfunction

  function automatic word_t round_f(input grp_e g, input word_t b, input word_t c,
                                    input word_t d);
    word_t f;
    case (g)
      GrpChoose:   f = (b & c) | (~b & d);
      GrpMajority: f = (b & c) | (b & d) | (c & d);
      default:     f = b ^ c ^ d;
    endcase
    return f;
  endfunction

  function automatic word_t round_k(input grp_e g);
    word_t k;
    case (g)
      GrpChoose:   k = 32'h5A827999;
      GrpParityA:  k = 32'h6ED9EBA1;
      GrpMajority: k = 32'h8F1BBCDC;
      default:     k = 32'hCA62C1D6;
    endcase
    return k;
  endfunction

endpackage

`default_nettype wire

### hw/rtl/sha1_stream_hasher_unit.sv
// sha1_stream_hasher_unit: streaming sha-1 engine, sequencer and chaining state
// depends on sha1sh_pkg, sha1sh_msg_sched and sha1sh_round_core
`default_nettype none

// Takes message bytes one beat at a time and returns the 20-byte SHA-1 digest as
// five 32-bit beats (word 0 first, last_word_o on word 4) after the beat marked
// last; a last beat with byte_present_i low closes the message without a byte,
// so a lone such beat hashes the empty message. Ordinary bytes are taken back to
// back while in_ready_o is high. The beat that completes a 64-byte block starts
// a compression that runs the single shared round unit through all 80 rounds
// (StRound), then folds the result into the chaining value (StAdd); in_ready_o
// is low throughout. After the last beat the padding bytes are shifted in one
// per cycle (up to 64, or up to 72 when the length no longer fits) with one or
// two compressions, during which shifting pauses; then the five digest beats
// are offered, and the engine then restarts from the initial chaining value.
// Bytes of a new block are not taken until the previous compression is done.

module sha1_stream_hasher_unit import sha1sh_pkg::*; (
  input  wire                 clk_i,
  input  wire                 rst_ni,
  // byte input
  input  wire                 in_valid_i,
  output logic                in_ready_o,
  input  wire  [7:0]          data_byte_i,
  input  wire                 byte_present_i,
  input  wire                 last_i,
  // digest output
  output logic                out_valid_o,
  input  wire                 out_ready_i,
  output logic [31:0]         digest_word_o,
  output logic [WordIdxW-1:0] word_index_o,
  output logic                last_word_o
);

  typedef enum logic [2:0] {
    StIdle,
    StRound,
    StAdd,
    StPad,
    StOut
  } state_e;

  state_e                state_q, state_d;
  chain_t                chain_q, chain_d;
  logic [LenW-1:0]       len_q, len_d;
  logic [PosW-1:0]       pos_q, pos_d;
  logic [WordIdxW-1:0]   idx_q, idx_d;
  logic                  pad_pend_q, pad_pend_d;
  logic                  pad_first_q, pad_first_d;
  logic                  len_phase_q, len_phase_d;
  logic                  pad_done_q, pad_done_d;

  sched_ctrl_t           sched_ctrl;
  round_ctrl_t           round_ctrl;
  word_t                 w;
  chain_t                vars;
  logic                  round_last;
  logic [7:0]            len_byte, pad_byte;

  sha1sh_msg_sched u_sched (
    .clk_i  (clk_i),
    .ctrl_i (sched_ctrl),
    .w_o    (w)
  );

  sha1sh_round_core u_round (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .ctrl_i  (round_ctrl),
    .chain_i (chain_q),
    .w_i     (w),
    .vars_o  (vars),
    .last_o  (round_last)
  );

  // padding byte: marker, zero fill, then big-endian bit length
  assign len_byte = 8'(len_q >> {3'(~pos_q[2:0]), 3'b000});
  always_comb begin
    if (pad_first_q) begin
      pad_byte = PadMark;
    end else if (len_phase_q || pos_q == LenPos) begin
      pad_byte = len_byte;
    end else begin
      pad_byte = 8'h00;
    end
  end

  // sequencer
  always_comb begin
    state_d     = state_q;
    chain_d     = chain_q;
    len_d       = len_q;
    pos_d       = pos_q;
    idx_d       = idx_q;
    pad_pend_d  = pad_pend_q;
    pad_first_d = pad_first_q;
    len_phase_d = len_phase_q;
    pad_done_d  = pad_done_q;
    sched_ctrl  = '0;
    round_ctrl  = '0;

    case (state_q)
      StIdle: begin
        if (in_valid_i) begin
          if (byte_present_i) begin
            sched_ctrl.shift_byte = 1'b1;
            sched_ctrl.byte_val   = data_byte_i;
            pos_d                 = pos_q + PosW'(1);
            len_d                 = len_q + LenW'(8);
          end
          if (last_i) begin
            pad_pend_d  = 1'b1;
            pad_first_d = 1'b1;
          end
          if (byte_present_i && pos_q == PosLast) begin
            round_ctrl.load = 1'b1;
            state_d         = StRound;
          end else if (last_i) begin
            state_d = StPad;
          end
        end
      end
      StRound: begin
        round_ctrl.step       = 1'b1;
        sched_ctrl.shift_word = 1'b1;
        if (round_last) begin
          state_d = StAdd;
        end
      end
      StAdd: begin
        for (int i = 0; i < NumWords; i++) begin
          chain_d[i] = chain_q[i] + vars[i];
        end
        if (!pad_pend_q) begin
          state_d = StIdle;
        end else if (pad_done_q) begin
          state_d = StOut;
        end else begin
          state_d = StPad;
        end
      end
      StPad: begin
        sched_ctrl.shift_byte = 1'b1;
        sched_ctrl.byte_val   = pad_byte;
        pos_d                 = pos_q + PosW'(1);
        pad_first_d           = 1'b0;
        if (!pad_first_q && pos_q == LenPos) begin
          len_phase_d = 1'b1;
        end
        if (pos_q == PosLast) begin
          pad_done_d      = len_phase_q;
          round_ctrl.load = 1'b1;
          state_d         = StRound;
        end
      end
      StOut: begin
        if (out_ready_i) begin
          if (idx_q == WordIdxW'(NumWords - 1)) begin
            idx_d       = '0;
            chain_d     = HInit;
            len_d       = '0;
            pad_pend_d  = 1'b0;
            len_phase_d = 1'b0;
            pad_done_d  = 1'b0;
            state_d     = StIdle;
          end else begin
            idx_d = idx_q + WordIdxW'(1);
          end
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  // state and chaining registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      chain_q     <= HInit;
      len_q       <= '0;
      pos_q       <= '0;
      idx_q       <= '0;
      pad_pend_q  <= 1'b0;
      pad_first_q <= 1'b0;
      len_phase_q <= 1'b0;
      pad_done_q  <= 1'b0;
    end else begin
      state_q     <= state_d;
      chain_q     <= chain_d;
      len_q       <= len_d;
      pos_q       <= pos_d;
      idx_q       <= idx_d;
      pad_pend_q  <= pad_pend_d;
      pad_first_q <= pad_first_d;
      len_phase_q <= len_phase_d;
      pad_done_q  <= pad_done_d;
    end
  end

  // handshake and digest beat
  assign in_ready_o    = (state_q == StIdle);
  assign out_valid_o   = (state_q == StOut);
  assign digest_word_o = chain_q[idx_q];
  assign word_index_o  = idx_q;
  assign last_word_o   = (idx_q == WordIdxW'(NumWords - 1));

endmodule

`default_nettype wire

### hw/rtl/sha1sh_msg_sched.sv
// sha1sh_msg_sched: 512-bit block shift line, filled a byte at a time and
// stepped a word per round to expand the message schedule; uses sha1sh_pkg
`default_nettype none

module sha1sh_msg_sched import sha1sh_pkg::*; (
  input  wire         clk_i,
  input  sched_ctrl_t ctrl_i,
  output word_t       w_o
);

  logic [MsgW-1:0] msg_q, msg_d;
  word_t           w0, w2, w8, w13, w_mix, w_new;

  // fixed taps of the sixteen-word window, w0 at the top
  assign w0  = msg_q[MsgW-1      -: 32];
  assign w2  = msg_q[MsgW-1-64   -: 32];
  assign w8  = msg_q[MsgW-1-256  -: 32];
  assign w13 = msg_q[MsgW-1-416  -: 32];

  // schedule expansion word
  assign w_mix = w13 ^ w8 ^ w2 ^ w0;
  assign w_new = {w_mix[30:0], w_mix[31]};

  always_comb begin
    msg_d = msg_q;
    if (ctrl_i.shift_byte) begin
      msg_d = {msg_q[MsgW-9:0], ctrl_i.byte_val};
    end else if (ctrl_i.shift_word) begin
      msg_d = {msg_q[MsgW-33:0], w_new};
    end
  end

  // block data needs no reset
  always_ff @(posedge clk_i) begin
    msg_q <= msg_d;
  end

  assign w_o = w0;

endmodule

`default_nettype wire

### hw/rtl/sha1sh_round_core.sv
// sha1sh_round_core: a..e working registers and one shared sha-1 round,
// applied once per cycle while ctrl_i.step is set, under a round counter; uses sha1sh_pkg
`default_nettype none

module sha1sh_round_core import sha1sh_pkg::*; (
  input  wire         clk_i,
  input  wire         rst_ni,
  input  round_ctrl_t ctrl_i,
  input  chain_t      chain_i,
  input  word_t       w_i,
  output chain_t      vars_o,
  output logic        last_o
);

  chain_t              v_q, v_d;
  logic [RoundW-1:0]   cnt_q, cnt_d;
  grp_e                grp;
  word_t               a, b, c, d, e, t;

  assign a = v_q[0];
  assign b = v_q[1];
  assign c = v_q[2];
  assign d = v_q[3];
  assign e = v_q[4];

  // one round
  always_comb begin
    grp = round_grp(cnt_q);
    t   = {a[26:0], a[31:27]} + round_f(grp, b, c, d) + e + round_k(grp) + w_i;
  end

  always_comb begin
    v_d   = v_q;
    cnt_d = cnt_q;
    if (ctrl_i.load) begin
      v_d   = chain_i;
      cnt_d = '0;
    end else if (ctrl_i.step) begin
      v_d[0] = t;
      v_d[1] = a;
      v_d[2] = {b[1:0], b[31:2]};
      v_d[3] = c;
      v_d[4] = d;
      cnt_d  = cnt_q + RoundW'(1);
    end
  end

  // round counter
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  // working variables
  always_ff @(posedge clk_i) begin
    v_q <= v_d;
  end

  assign vars_o = v_q;
  assign last_o = (cnt_q == RoundW'(NumRounds - 1));

endmodule

`default_nettype wire
